// File: sv/tiltq_pkg.sv
// Package for the tilt orientation qualifier.
// Holds register map, reset values and the orientation mode codes.
// No dependencies; used by tilt_orientation_qualifier_top.
package tiltq_pkg;

    // Field widths
    localparam int unsigned AccelW  = 16;
    localparam int unsigned ThreshW = 15;
    localparam int unsigned HoldW   = 8;
    localparam int unsigned ModeN   = 4;

    // APB register map (byte addresses 0 and 4)
    localparam int unsigned AddrW = 3;
    localparam int unsigned DataW = 32;

    typedef enum logic [0:0] {
        REG_TILT_THRESHOLD = 1'b0,
        REG_HOLD_COUNT     = 1'b1
    } reg_idx_t;

    // Register reset values
    localparam logic [ThreshW-1:0] ThreshReset = 15'd240;
    localparam logic [HoldW-1:0]   HoldReset   = 8'd100;

    // Orientation modes; each also names its persistence counter
    typedef enum logic [1:0] {
        MODE_Y_NEG = 2'd0,
        MODE_X_POS = 2'd1,
        MODE_Y_POS = 2'd2,
        MODE_X_NEG = 2'd3
    } mode_t;

endpackage

// File: sv/tilt_orientation_qualifier_top.sv
// Tilt orientation qualifier: top level with APB registers and sample pipeline.
// Depends on tiltq_pkg (register map, mode codes, reset values).
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  sample   | sample_valid/sample_ready  | accel_x, accel_y (s16)
//  result   | result_valid/result_ready  | orientation (2b), mode_changed
//  config   | APB psel/penable/pready    | paddr (3b), pwdata/prdata (32b)
//
// Each beat passes through the input register and then the result register;
// one beat per cycle is sustained while result_ready stays high.
// The counter/mode update happens as a beat moves from the input register
// to the result register, so back-to-back beats see each other's state.
// A stalled result holds both stages; sample_ready drops only when both full.
// rst_n clears counters, mode, valid flags and restores register defaults.
module tilt_orientation_qualifier_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tiltq_pkg::AddrW-1:0]       paddr,
    input  logic [tiltq_pkg::DataW-1:0]       pwdata,
    output logic [tiltq_pkg::DataW-1:0]       prdata,
    output logic                              pready,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic signed [tiltq_pkg::AccelW-1:0] accel_x,
    input  logic signed [tiltq_pkg::AccelW-1:0] accel_y,
    // result channel
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [1:0]                        orientation,
    output logic                              mode_changed
);

    localparam int unsigned CmpW = tiltq_pkg::AccelW + 1;

    // Configuration registers
    logic [tiltq_pkg::ThreshW-1:0] thresh_reg;
    logic [tiltq_pkg::HoldW-1:0]   hold_reg;
    logic                          cfg_wr;
    tiltq_pkg::reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = tiltq_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= tiltq_pkg::ThreshReset;
            hold_reg   <= tiltq_pkg::HoldReset;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                tiltq_pkg::REG_TILT_THRESHOLD: thresh_reg <= pwdata[tiltq_pkg::ThreshW-1:0];
                tiltq_pkg::REG_HOLD_COUNT:     hold_reg   <= pwdata[tiltq_pkg::HoldW-1:0];
                default:                       ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            tiltq_pkg::REG_TILT_THRESHOLD:
                prdata = {{(tiltq_pkg::DataW-tiltq_pkg::ThreshW){1'b0}}, thresh_reg};
            tiltq_pkg::REG_HOLD_COUNT:
                prdata = {{(tiltq_pkg::DataW-tiltq_pkg::HoldW){1'b0}}, hold_reg};
            default:
                prdata = '0;
        endcase
    end

    // Pipeline handshake
    logic in_valid_reg;
    logic result_valid_reg;
    logic advance;

    assign advance      = in_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign result_valid = result_valid_reg;

    // Input register
    logic signed [tiltq_pkg::AccelW-1:0] x_reg;
    logic signed [tiltq_pkg::AccelW-1:0] y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            x_reg <= accel_x;
            y_reg <= accel_y;
        end
    end

    // Threshold tests, 17-bit signed so -threshold always fits
    logic signed [CmpW-1:0] thr_pos;
    logic signed [CmpW-1:0] thr_neg;
    logic signed [CmpW-1:0] x_ext;
    logic signed [CmpW-1:0] y_ext;
    logic                   qual;
    tiltq_pkg::mode_t       qual_mode;

    assign thr_pos = $signed({{(CmpW-tiltq_pkg::ThreshW){1'b0}}, thresh_reg});
    assign thr_neg = -thr_pos;
    assign x_ext   = CmpW'(x_reg);
    assign y_ext   = CmpW'(y_reg);

    always_comb
    begin
        qual      = 1'b1;
        qual_mode = tiltq_pkg::MODE_Y_NEG;
        priority if (y_ext < thr_neg)
            qual_mode = tiltq_pkg::MODE_Y_NEG;
        else if (y_ext > thr_pos)
            qual_mode = tiltq_pkg::MODE_Y_POS;
        else if (x_ext > thr_pos)
            qual_mode = tiltq_pkg::MODE_X_POS;
        else if (x_ext < thr_neg)
            qual_mode = tiltq_pkg::MODE_X_NEG;
        else
            qual = 1'b0;
    end

    // Persistence counters and mode
    logic [tiltq_pkg::HoldW-1:0] cnt_reg [tiltq_pkg::ModeN];
    logic [tiltq_pkg::HoldW-1:0] cnt_next [tiltq_pkg::ModeN];
    tiltq_pkg::mode_t            mode_reg;
    tiltq_pkg::mode_t            mode_next;
    logic [tiltq_pkg::HoldW:0]   cnt_inc;
    logic                        reached;

    assign cnt_inc = {1'b0, cnt_reg[qual_mode]} + 1'b1;
    assign reached = cnt_inc >= {1'b0, hold_reg};

    always_comb
    begin
        mode_next = mode_reg;
        for (int i = 0; i < tiltq_pkg::ModeN; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (qual)
        begin
            for (int i = 0; i < tiltq_pkg::ModeN; i++)
            begin
                cnt_next[i] = '0;
            end
            if (reached)
            begin
                cnt_next[qual_mode] = hold_reg;
                mode_next           = qual_mode;
            end
            else
            begin
                cnt_next[qual_mode] = cnt_inc[tiltq_pkg::HoldW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tiltq_pkg::ModeN; i++)
            begin
                cnt_reg[i] <= '0;
            end
            mode_reg <= tiltq_pkg::MODE_Y_NEG;
        end
        else if (advance)
        begin
            for (int i = 0; i < tiltq_pkg::ModeN; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            mode_reg <= mode_next;
        end
    end

    // Result register
    logic [1:0] orient_reg;
    logic       changed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            orient_reg  <= mode_next;
            changed_reg <= (mode_next != mode_reg);
        end
    end

    assign orientation  = orient_reg;
    assign mode_changed = changed_reg;

    // Assertions

    // at most one persistence counter is ever nonzero
    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({|cnt_reg[0], |cnt_reg[1], |cnt_reg[2], |cnt_reg[3]}) <= 1)
        else $error("more than one persistence counter nonzero");

    // the mode moves only when a beat goes through the update
    a_mode_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(mode_reg))
        else $error("mode changed without a beat");

    // the change flag matches the mode transition of the same beat
    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (changed_reg == (mode_reg != $past(mode_reg)))
                    && (orient_reg == mode_reg))
        else $error("result disagrees with mode update");

endmodule
